>>> design/dmxft_pkg.sv
// Package for the DMX frame transmitter: item structs, phase and
// sequencer enums, timing constants. No dependencies.
package dmxft_pkg;

    localparam int LED_W   = 8;
    localparam int LEVEL_W = 8;
    localparam int TIMER_W = 16;
    localparam int BASE_W  = 10;

    localparam int US_PER_CHANNEL = 44;
    localparam int DRAIN_EXTRA_US = 100;
    localparam logic [TIMER_W-1:0] BREAK_WAIT_US = 16'd150;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_COLOR = 1'b1;

    localparam logic FRAMING_BREAK = 1'b0;
    localparam logic FRAMING_DATA  = 1'b1;

    localparam logic [1:0] LVL_LAST = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BREAK,
        PH_DATA,
        PH_DRAIN
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_COLOR,
        SQ_EMIT,
        SQ_BURST
    } t_seq_state;

    typedef struct packed {
        logic               mode;
        logic [7:0]         elapsed_us;
        logic [4:0]         tx_space;
        logic [LED_W-1:0]   led_number;
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
    } t_in_item;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       line_framing;
        logic       last_of_run;
    } t_out_item;

endpackage

>>> design/dmxft_store.sv
// Channel store: single-write, single-read synchronous memory with
// a zeroing sweep after reset. Depends on dmxft_pkg.
module dmxft_store
    import dmxft_pkg::*;
#(
    parameter int CHANNEL_COUNT = 27,
    parameter int AW            = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [LEVEL_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [AW-1:0]      i_raddr,
    output logic [LEVEL_W-1:0] o_rdata,
    output logic               o_clr_busy
);

    logic [LEVEL_W-1:0] r_mem [CHANNEL_COUNT];
    logic [LEVEL_W-1:0] r_rdata;
    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_addr;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [LEVEL_W-1:0] wr_data;

    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = i_we;
            wr_addr = i_waddr;
            wr_data = i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(CHANNEL_COUNT - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clr_busy = r_clr_busy;

endmodule

>>> design/dmxft_seq.sv
// Frame sequencer: item decode, color read-modify-write, phase timer,
// byte bursts from the store, output register. Depends on dmxft_pkg.
module dmxft_seq
    import dmxft_pkg::*;
#(
    parameter int CHANNEL_COUNT  = 27,
    parameter int FIFO_SPACE_MAX = 16,
    parameter int AW             = 5,
    parameter int CW             = 5,
    parameter int SW             = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_item,
    input  logic               i_clr_busy,
    input  logic [LEVEL_W-1:0] i_rdata,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [LEVEL_W-1:0] o_wdata,
    output logic               o_re,
    output logic [AW-1:0]      o_raddr
);

    localparam int XW      = (CW > SW) ? CW : SW;
    localparam int LED_MAX = CHANNEL_COUNT / 3;
    localparam logic [TIMER_W-1:0] DRAIN_US =
        TIMER_W'(CHANNEL_COUNT * US_PER_CHANNEL + DRAIN_EXTRA_US);

    t_seq_state r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [TIMER_W-1:0]        r_timer, n_timer;
    logic                      r_dirty, n_dirty;
    logic [CW-1:0]             r_next_ch, n_next_ch;
    logic [SW-1:0]             r_cnt, n_cnt;
    logic [1:0]                r_k, n_k;
    logic [AW-1:0]             r_addr, n_addr;
    logic [2:0][LEVEL_W-1:0]   r_lvl, n_lvl;
    logic                      r_emit_framing, n_emit_framing;
    t_out_item                 r_out, n_out;
    logic                      r_out_valid, n_out_valid;

    logic              acc;
    logic              out_free;
    logic              led_ok;
    logic [BASE_W-1:0] led_m1;
    logic [BASE_W-1:0] base_w;
    logic [TIMER_W:0]  sum_w;
    logic [TIMER_W-1:0] timer_sat;
    logic [SW-1:0]     space_c;
    logic [CW-1:0]     left;
    logic [XW-1:0]     left_x;
    logic [XW-1:0]     space_x;
    logic [XW-1:0]     cnt_x;
    logic              start_emit;
    logic              start_burst;

    assign o_in_ready = (r_state == SQ_IDLE) && !i_clr_busy;
    assign acc        = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign led_ok = (i_in_item.led_number != '0) &&
                    (32'(i_in_item.led_number) <= LED_MAX);
    assign led_m1 = BASE_W'(i_in_item.led_number) - BASE_W'(1);
    assign base_w = (led_m1 << 1) + led_m1;

    assign sum_w     = {1'b0, r_timer} + (TIMER_W + 1)'(i_in_item.elapsed_us);
    assign timer_sat = sum_w[TIMER_W] ? '1 : sum_w[TIMER_W-1:0];

    assign space_c = (32'(i_in_item.tx_space) > FIFO_SPACE_MAX) ?
                     SW'(FIFO_SPACE_MAX) : SW'(i_in_item.tx_space);
    assign left    = CW'(CHANNEL_COUNT) - r_next_ch;
    assign left_x  = XW'(left);
    assign space_x = XW'(space_c);
    assign cnt_x   = (left_x < space_x) ? left_x : space_x;

    assign start_emit  = ((r_phase == PH_IDLE) && r_dirty) ||
                         ((r_phase == PH_BREAK) && (timer_sat >= BREAK_WAIT_US));
    assign start_burst = (r_phase == PH_DATA) && (space_c != '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            SQ_IDLE: begin
                if (acc) begin
                    if (i_in_item.mode == MODE_COLOR) begin
                        n_state = led_ok ? SQ_COLOR : SQ_IDLE;
                    end else if (start_emit) begin
                        n_state = SQ_EMIT;
                    end else if (start_burst) begin
                        n_state = SQ_BURST;
                    end
                end
            end
            SQ_COLOR: begin
                if (r_k == LVL_LAST) begin
                    n_state = SQ_IDLE;
                end
            end
            SQ_EMIT: begin
                if (out_free) begin
                    n_state = SQ_IDLE;
                end
            end
            SQ_BURST: begin
                if (out_free && (r_cnt == SW'(1))) begin
                    n_state = SQ_IDLE;
                end
            end
            default: n_state = SQ_IDLE;
        endcase
    end

    always_comb begin
        n_phase        = r_phase;
        n_timer        = r_timer;
        n_dirty        = r_dirty;
        n_next_ch      = r_next_ch;
        n_cnt          = r_cnt;
        n_k            = r_k;
        n_addr         = r_addr;
        n_lvl          = r_lvl;
        n_emit_framing = r_emit_framing;
        n_out          = r_out;
        n_out_valid    = r_out_valid && !i_out_ready;
        o_we           = 1'b0;
        o_waddr        = r_addr;
        o_wdata        = r_lvl[0];
        o_re           = 1'b0;
        o_raddr        = r_addr;
        case (r_state)
            SQ_IDLE: begin
                if (acc) begin
                    if (i_in_item.mode == MODE_COLOR) begin
                        if (led_ok) begin
                            n_addr  = AW'(base_w);
                            n_k     = '0;
                            n_lvl   = {i_in_item.blue_level, i_in_item.green_level,
                                       i_in_item.red_level};
                            o_re    = 1'b1;
                            o_raddr = AW'(base_w);
                        end
                    end else begin
                        n_timer = timer_sat;
                        case (r_phase)
                            PH_IDLE: begin
                                if (r_dirty) begin
                                    n_timer        = '0;
                                    n_dirty        = 1'b0;
                                    n_phase        = PH_BREAK;
                                    n_emit_framing = FRAMING_BREAK;
                                end
                            end
                            PH_BREAK: begin
                                if (timer_sat >= BREAK_WAIT_US) begin
                                    n_timer        = '0;
                                    n_next_ch      = '0;
                                    n_phase        = PH_DATA;
                                    n_emit_framing = FRAMING_DATA;
                                end
                            end
                            PH_DATA: begin
                                if (space_c != '0) begin
                                    n_cnt   = SW'(cnt_x);
                                    o_re    = 1'b1;
                                    o_raddr = AW'(r_next_ch);
                                    if (left_x <= space_x) begin
                                        n_phase = PH_DRAIN;
                                    end
                                end
                            end
                            PH_DRAIN: begin
                                if (timer_sat >= DRAIN_US) begin
                                    n_phase = PH_IDLE;
                                end
                            end
                            default: n_phase = PH_IDLE;
                        endcase
                    end
                end
            end
            SQ_COLOR: begin
                o_we    = 1'b1;
                o_waddr = r_addr;
                o_wdata = r_lvl[0];
                if (i_rdata != r_lvl[0]) begin
                    n_dirty = 1'b1;
                end
                n_lvl = {{LEVEL_W{1'b0}}, r_lvl[2:1]};
                if (r_k != LVL_LAST) begin
                    o_re    = 1'b1;
                    o_raddr = r_addr + AW'(1);
                    n_addr  = r_addr + AW'(1);
                    n_k     = r_k + 2'd1;
                end
            end
            SQ_EMIT: begin
                if (out_free) begin
                    n_out       = '{byte_value: 8'h00, line_framing: r_emit_framing,
                                    last_of_run: 1'b1};
                    n_out_valid = 1'b1;
                end
            end
            SQ_BURST: begin
                if (out_free) begin
                    n_out       = '{byte_value: i_rdata, line_framing: FRAMING_DATA,
                                    last_of_run: (r_cnt == SW'(1))};
                    n_out_valid = 1'b1;
                    n_next_ch   = r_next_ch + CW'(1);
                    n_cnt       = r_cnt - SW'(1);
                    if (r_cnt != SW'(1)) begin
                        o_re    = 1'b1;
                        o_raddr = AW'(r_next_ch + CW'(1));
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SQ_IDLE;
            r_phase     <= PH_IDLE;
            r_timer     <= '0;
            r_dirty     <= 1'b1;
            r_next_ch   <= '0;
            r_cnt       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_timer     <= n_timer;
            r_dirty     <= n_dirty;
            r_next_ch   <= n_next_ch;
            r_cnt       <= n_cnt;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr         <= n_addr;
        r_lvl          <= n_lvl;
        r_emit_framing <= n_emit_framing;
        r_out          <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef NO_ASSERTIONS
    a_burst_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQ_BURST) |-> (r_cnt != '0))
        else $error("burst running with zero count");

    a_data_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_next_ch < CW'(CHANNEL_COUNT)))
        else $error("data phase past last channel");

    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SQ_BURST) && out_free && (r_cnt == SW'(1)) |=>
        (r_state == SQ_IDLE) && o_out_valid && o_out_item.last_of_run)
        else $error("burst end not marked");

    a_clr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clr_busy |-> !o_in_ready && !o_we)
        else $error("activity during store clear");
`endif

endmodule

>>> design/dmx_frame_transmitter_core.sv
// Top level of the DMX frame transmitter: channel store and frame sequencer.
// Depends on dmxft_pkg, dmxft_store, dmxft_seq.
//
// After reset the channel store is zeroed, during which no item is taken.
// One item is handled at a time through the single-write, single-read
// store: a color write is one read, then three read-modify-write steps; a
// tick that sends the break or start code sends one output byte; a tick in
// the data phase that sends n bytes sends one byte per cycle from the store
// read port while the output is not stalled.
module dmx_frame_transmitter_core
    import dmxft_pkg::*;
#(
    parameter int CHANNEL_COUNT  = 27,
    parameter int FIFO_SPACE_MAX = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int AW = $clog2(CHANNEL_COUNT);
    localparam int CW = $clog2(CHANNEL_COUNT + 1);
    localparam int SW = $clog2(FIFO_SPACE_MAX + 1);

    logic               clr_busy;
    logic [LEVEL_W-1:0] rdata;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [LEVEL_W-1:0] wdata;
    logic               re;
    logic [AW-1:0]      raddr;

    dmxft_store #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .AW            (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (we),
        .i_waddr    (waddr),
        .i_wdata    (wdata),
        .i_re       (re),
        .i_raddr    (raddr),
        .o_rdata    (rdata),
        .o_clr_busy (clr_busy)
    );

    dmxft_seq #(
        .CHANNEL_COUNT  (CHANNEL_COUNT),
        .FIFO_SPACE_MAX (FIFO_SPACE_MAX),
        .AW             (AW),
        .CW             (CW),
        .SW             (SW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_clr_busy  (clr_busy),
        .i_rdata     (rdata),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr)
    );

endmodule

>>> sim/dmxft_checker.sv
// Scoreboard for the DMX frame transmitter: watches both item channels, predicts
// the bytes each accepted item should send, and compares them in order.
// Depends on dmxft_pkg.
`timescale 1ns / 100ps
module dmxft_checker
    import dmxft_pkg::*;
#(
    parameter int CHANNEL_COUNT  = 27,
    parameter int FIFO_SPACE_MAX = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int DRAIN_US  = CHANNEL_COUNT * US_PER_CHANNEL + DRAIN_EXTRA_US;
    localparam int TIMER_MAX = (1 << TIMER_W) - 1;

    logic [LEVEL_W-1:0] levels [CHANNEL_COUNT];
    t_phase             phase;
    logic [BASE_W-1:0]  next_ch;
    logic               dirty;
    logic [TIMER_W-1:0] timer_us;
    t_out_item          uart_bytes_q[$];
    t_out_item          want;

    function automatic void push_byte(input logic [7:0] value, input logic framing);
        t_out_item r;
        r.byte_value   = value;
        r.line_framing = framing;
        r.last_of_run  = 1'b0;
        uart_bytes_q.push_back(r);
    endfunction

    function automatic void apply_item(input t_in_item it);
        int        base;
        int        sum;
        int        space;
        int        left;
        int        first;
        t_out_item r;
        if (it.mode == MODE_COLOR) begin
            if (it.led_number != 0) begin
                base = (int'(it.led_number) - 1) * 3;
                if (base + 2 < CHANNEL_COUNT) begin
                    if (levels[base] != it.red_level) begin
                        levels[base] = it.red_level;
                        dirty = 1'b1;
                    end
                    if (levels[base+1] != it.green_level) begin
                        levels[base+1] = it.green_level;
                        dirty = 1'b1;
                    end
                    if (levels[base+2] != it.blue_level) begin
                        levels[base+2] = it.blue_level;
                        dirty = 1'b1;
                    end
                end
            end
            return;
        end
        sum = int'(timer_us) + int'(it.elapsed_us);
        timer_us = (sum > TIMER_MAX) ? '1 : sum[TIMER_W-1:0];
        first = uart_bytes_q.size();
        case (phase)
            PH_IDLE: begin
                if (dirty) begin
                    push_byte(8'h00, FRAMING_BREAK);
                    timer_us = '0;
                    dirty    = 1'b0;
                    phase    = PH_BREAK;
                end
            end
            PH_BREAK: begin
                if (timer_us >= BREAK_WAIT_US) begin
                    push_byte(8'h00, FRAMING_DATA);
                    timer_us = '0;
                    next_ch  = '0;
                    phase    = PH_DATA;
                end
            end
            PH_DATA: begin
                space = (int'(it.tx_space) > FIFO_SPACE_MAX) ? FIFO_SPACE_MAX
                                                             : int'(it.tx_space);
                if (space != 0) begin
                    left = (int'(next_ch) < CHANNEL_COUNT) ?
                           CHANNEL_COUNT - int'(next_ch) : 0;
                    if (left > space)
                        left = space;
                    for (int i = 0; i < left; i++) begin
                        push_byte(levels[next_ch], FRAMING_DATA);
                        next_ch = next_ch + 1'b1;
                    end
                    if (int'(next_ch) >= CHANNEL_COUNT)
                        phase = PH_DRAIN;
                end
            end
            default: begin
                if (int'(timer_us) >= DRAIN_US)
                    phase = PH_IDLE;
            end
        endcase
        if (uart_bytes_q.size() > first) begin
            r = uart_bytes_q.pop_back();
            r.last_of_run = 1'b1;
            uart_bytes_q.push_back(r);
        end
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (levels[i])
                levels[i] = '0;
            phase    = PH_IDLE;
            next_ch  = '0;
            dirty    = 1'b1;
            timer_us = '0;
            uart_bytes_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                apply_item(i_in_item);
            if (i_out_valid && i_out_ready) begin
                if (uart_bytes_q.size() == 0) begin
                    $display({"%0t: unexpected item, expected none, ",
                              "actual byte %02h framing %0d last %0d"},
                             $time, i_out_item.byte_value, i_out_item.line_framing,
                             i_out_item.last_of_run);
                    o_fail_count++;
                end else begin
                    want = uart_bytes_q.pop_front();
                    check_field("byte_value", want.byte_value, i_out_item.byte_value);
                    check_field("line_framing", want.line_framing, i_out_item.line_framing);
                    check_field("last_of_run", want.last_of_run, i_out_item.last_of_run);
                end
            end
        end
        o_pending = uart_bytes_q.size();
    end

endmodule

>>> sim/tb.sv
// Testbench top for dmx_frame_transmitter_core: clock, reset, directed and
// random item streams with flow-control pressure, and the verdict.
// Depends on dmxft_pkg, dmx_frame_transmitter_core, dmxft_checker.
`timescale 1ns / 100ps
module tb;
    import dmxft_pkg::*;

    localparam int CHANNEL_COUNT  = 27;
    localparam int FIFO_SPACE_MAX = 16;
    localparam int LED_COUNT      = CHANNEL_COUNT / 3;
    localparam int HOLD_CYCLES    = 400;
    localparam int SAT_TICKS      = 260;
    localparam int RAND_PER_MODE  = 13;
    localparam int LIMIT_NS       = 2_000_000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    logic      hold_req  = 1'b0;
    int        snd_idle_pct = 16;
    int        rcv_idle_pct = 73;
    int        fail_count;
    int        pending;

    always #5 clk = ~clk;

    dmx_frame_transmitter_core #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .FIFO_SPACE_MAX(FIFO_SPACE_MAX)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    dmxft_checker #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .FIFO_SPACE_MAX(FIFO_SPACE_MAX)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    function automatic t_in_item tick(input int el, input int sp);
        t_in_item it;
        it            = '0;
        it.mode       = MODE_TICK;
        it.elapsed_us = el[7:0];
        it.tx_space   = sp[4:0];
        return it;
    endfunction

    function automatic t_in_item color(input int led, input int r, input int g, input int b);
        t_in_item it;
        it             = '0;
        it.mode        = MODE_COLOR;
        it.led_number  = led[7:0];
        it.red_level   = r[7:0];
        it.green_level = g[7:0];
        it.blue_level  = b[7:0];
        return it;
    endfunction

    function automatic logic [7:0] pick_level();
        if ($urandom_range(1))
            return 8'($urandom_range(255));
        return $urandom_range(1) ? 8'hFF : 8'h00;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.elapsed_us  = 8'($urandom_range(255));
        it.tx_space    = 5'($urandom_range(31));
        it.led_number  = 8'($urandom_range(255));
        it.red_level   = pick_level();
        it.green_level = pick_level();
        it.blue_level  = pick_level();
        if ($urandom_range(3) == 0) begin
            it.mode = MODE_COLOR;
            if ($urandom_range(9) < 7)
                it.led_number = 8'($urandom_range(LED_COUNT, 1));
        end else begin
            it.mode = MODE_TICK;
            case ($urandom_range(3))
                0:       it.elapsed_us = 8'hFF;
                1:       it.elapsed_us = 8'($urandom_range(20));
                default: ;
            endcase
            case ($urandom_range(9))
                0, 1, 2: it.tx_space = 5'(FIFO_SPACE_MAX);
                3, 4:    it.tx_space = '0;
                5, 6:    it.tx_space = 5'($urandom_range(4, 1));
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic send(input t_in_item it);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // receiver: random stalls, plus one long hold when requested
    initial begin : receiver
        logic seen_req;
        seen_req = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req != seen_req) begin
                seen_req = hold_req;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: break/start boundaries, ignored LEDs, writes mid-frame
        send(tick(0, 0));
        send(tick(149, 0));
        send(tick(1, 0));
        send(tick(0, 0));
        send(color(LED_COUNT, 255, 254, 253));
        send(color(0, 1, 1, 1));
        send(color(LED_COUNT + 1, 5, 6, 7));
        send(color(255, 9, 9, 9));
        send(tick(0, 31));
        send(color(1, 8'h80, 8'h01, 8'hFF));
        send(tick(0, 1));
        send(tick(0, 17));
        repeat (5) send(tick(255, 0));
        send(tick(13, 0));
        send(tick(0, 0));
        send(color(LED_COUNT, 255, 254, 253));
        send(color(1, 8'h80, 8'h01, 8'hFF));

        // timer saturation while stuck in data phase
        send(tick(200, 0));
        repeat (SAT_TICKS) send(tick(255, 0));
        send(tick(0, 16));
        send(tick(0, 16));
        send(tick(0, 0));
        send(tick(0, 0));

        // long receiver hold during a full frame, then let everything drain
        send(color(3, 77, 88, 99));
        hold_req <= ~hold_req;
        send(tick(0, 0));
        send(tick(150, 0));
        send(tick(0, 16));
        send(tick(0, 16));
        wait_drained();

        for (int m = 0; m < 3; m++) begin
            snd_idle_pct = (m == 0) ? 16 : (m == 1) ? 73 : 0;
            rcv_idle_pct = (m == 0) ? 73 : (m == 1) ? 16 : 0;
            repeat (RAND_PER_MODE) send(rand_item());
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
